FILE: hdl/pir_pkg.sv
// pir_pkg: shared widths, codes and controller/datapath interface types
// for the packed id registry; no dependencies
`timescale 1ns / 1ps

package pir_pkg;

    localparam int CMD_W            = 2;
    localparam int ID_W             = 20;
    localparam int IDX_W            = 8;
    localparam int STATUS_W         = 2;
    localparam int CNT_OUT_W        = 9;
    localparam int PACK_W           = 24;
    localparam int PAIR_W           = 7;
    localparam int DEFAULT_CAPACITY = 256;

    localparam logic [ID_W-1:0] ID_MODULUS = 20'd1000000;
    localparam logic [ID_W-1:0] HI_WEIGHT  = 20'd10000;
    localparam logic [ID_W-1:0] MID_WEIGHT = 20'd100;
    localparam logic [7:0]      PAIR_MARK  = 8'h80;

    // reciprocals for the divisions by 10000 and 100
    localparam logic [ID_W-1:0] HI_RECIP  = 20'd858994;
    localparam int              HI_SHIFT  = 33;
    localparam logic [ID_W-1:0] MID_RECIP = 20'd10486;
    localparam int              MID_SHIFT = 20;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_code_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic scan_step;
        logic scan_end;
        logic fetch_take;
        logic result_load;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t op;
        logic      full;
        logic      idx_oor;
        logic      scan_done;
        logic      found;
        logic      pack_done;
    } dp_sts_t;

endpackage

FILE: hdl/packed_id_registry.sv
// packed_id_registry: top level of the ordered six-digit id list
// instantiates pir_ctrl and pir_datapath; uses pir_pkg
`timescale 1ns / 1ps

// One request at a time. A request is taken while the previous result still
// waits in the output register. Clear, an add that finds the list full and a
// read out of range go straight to the result; a successful add and an
// in-range read pass through the digit-pair conversion unit, which works by
// reciprocal multiplication. A remove scans the table memory one entry per
// cycle, searching and shifting later entries down in the same pass, and a
// found match then passes through the conversion unit as well. A stalled
// result adds its stall; the next request can be taken at the same edge as the
// result is taken. Identifiers of a million or more are reduced modulo one
// million on entry; found_position shows the low bits of its internal value
// when CAPACITY exceeds 256, and entry_count when CAPACITY exceeds 511.

module packed_id_registry #(
    parameter int CAPACITY = pir_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [pir_pkg::CMD_W-1:0]     s_cmd,
    input  logic [pir_pkg::ID_W-1:0]      s_id_value,
    input  logic [pir_pkg::IDX_W-1:0]     s_entry_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [pir_pkg::STATUS_W-1:0]  m_status,
    output logic [pir_pkg::CNT_OUT_W-1:0] m_entry_count,
    output logic [pir_pkg::IDX_W-1:0]     m_found_position,
    output logic [pir_pkg::ID_W-1:0]      m_entry_id,
    output logic [pir_pkg::PACK_W-1:0]    m_entry_packed
);
    import pir_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_sts_t   dp_sts;

    pir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (ctrl_cmd),
        .sts     (dp_sts)
    );

    pir_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (ctrl_cmd),
        .sts              (dp_sts),
        .s_cmd            (s_cmd),
        .s_id_value       (s_id_value),
        .s_entry_index    (s_entry_index),
        .m_status         (m_status),
        .m_entry_count    (m_entry_count),
        .m_found_position (m_found_position),
        .m_entry_id       (m_entry_id),
        .m_entry_packed   (m_entry_packed)
    );

endmodule

FILE: hdl/pir_pack.sv
// pir_pack: converts an id below 1000000 into three marked base-100 digit pairs
// by reciprocal multiplication in the steps hi, rem, mid and lo; uses pir_pkg
`timescale 1ns / 1ps

module pir_pack (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [pir_pkg::ID_W-1:0]  value,
    output logic                      done,
    output logic [pir_pkg::PACK_W-1:0] packed_id
);
    import pir_pkg::*;

    typedef enum logic [3:0] {
        P_HI  = 4'b0001,
        P_REM = 4'b0010,
        P_MID = 4'b0100,
        P_LO  = 4'b1000
    } pack_step_t;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    pack_step_t        step_reg, step_next;
    logic [ID_W-1:0]   val_reg, val_next;
    logic [ID_W-1:0]   rem_reg, rem_next;
    logic [PAIR_W-1:0] hi_reg, hi_next;
    logic [PAIR_W-1:0] mid_reg, mid_next;
    logic [PAIR_W-1:0] lo_reg, lo_next;

    logic [2*ID_W-1:0] hi_prod;
    logic [2*ID_W-1:0] mid_prod;
    logic [ID_W-1:0]   hi_part;
    logic [ID_W-1:0]   mid_part;
    logic [ID_W-1:0]   lo_full;

    always_comb begin
        // quotients are exact for every value below 1000000
        hi_prod  = {{ID_W{1'b0}}, val_reg} * {{ID_W{1'b0}}, HI_RECIP};
        mid_prod = {{ID_W{1'b0}}, rem_reg} * {{ID_W{1'b0}}, MID_RECIP};
        hi_part  = {{(ID_W-PAIR_W){1'b0}}, hi_reg} * HI_WEIGHT;
        mid_part = {{(ID_W-PAIR_W){1'b0}}, mid_reg} * MID_WEIGHT;
        lo_full  = rem_reg - mid_part;

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        val_next  = val_reg;
        rem_next  = rem_reg;
        hi_next   = hi_reg;
        mid_next  = mid_reg;
        lo_next   = lo_reg;

        if (start) begin
            busy_next = 1'b1;
            step_next = P_HI;
            val_next  = value;
        end else if (busy_reg) begin
            unique case (step_reg)
                P_HI: begin
                    hi_next   = hi_prod[HI_SHIFT +: PAIR_W];
                    step_next = P_REM;
                end
                P_REM: begin
                    rem_next  = val_reg - hi_part;
                    step_next = P_MID;
                end
                P_MID: begin
                    mid_next  = mid_prod[MID_SHIFT +: PAIR_W];
                    step_next = P_LO;
                end
                P_LO: begin
                    lo_next   = lo_full[PAIR_W-1:0];
                    busy_next = 1'b0;
                    done_next = 1'b1;
                    step_next = P_HI;
                end
                default: begin
                    busy_next = 1'b0;
                    step_next = P_HI;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= P_HI;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        val_reg <= val_next;
        rem_reg <= rem_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        lo_reg  <= lo_next;
    end

    assign done      = done_reg;
    assign packed_id = {PAIR_MARK | {1'b0, hi_reg},
                        PAIR_MARK | {1'b0, mid_reg},
                        PAIR_MARK | {1'b0, lo_reg}};

    // done pulse only right after the last step
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("pack done without a finished conversion");

endmodule

FILE: hdl/pir_ctrl.sv
// pir_ctrl: request sequencing state machine for the packed id registry
// drives datapath commands from its status; uses pir_pkg
`timescale 1ns / 1ps

module pir_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output pir_pkg::ctrl_cmd_t cmd,
    input  pir_pkg::dp_sts_t   sts
);
    import pir_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_EXEC   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_FETCH  = 6'b001000,
        S_PACK   = 6'b010000,
        S_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        s_ready      = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                unique case (sts.op)
                    CMD_ADD:    state_next = sts.full ? S_FINISH : S_PACK;
                    CMD_REMOVE: state_next = S_SCAN;
                    CMD_READ:   state_next = sts.idx_oor ? S_FINISH : S_FETCH;
                    CMD_CLEAR:  state_next = S_FINISH;
                    default:    state_next = S_FINISH;
                endcase
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    cmd.scan_end = 1'b1;
                    state_next   = sts.found ? S_PACK : S_FINISH;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FETCH: begin
                cmd.fetch_take = 1'b1;
                state_next     = S_PACK;
            end
            S_PACK: begin
                if (sts.pack_done) begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.result_load = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    // conversions are only started on the way into the pack wait
    a_pack_done_in_pack: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.pack_done |-> state_reg == S_PACK)
        else $error("pack finished outside the pack wait");

endmodule

FILE: hdl/pir_datapath.sv
// pir_datapath: id table memory, entry count, search and shift scan, result registers
// depends on pir_pkg and pir_pack
`timescale 1ns / 1ps

module pir_datapath #(
    parameter int CAPACITY = pir_pkg::DEFAULT_CAPACITY
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pir_pkg::ctrl_cmd_t            cmd,
    output pir_pkg::dp_sts_t              sts,
    input  logic [pir_pkg::CMD_W-1:0]     s_cmd,
    input  logic [pir_pkg::ID_W-1:0]      s_id_value,
    input  logic [pir_pkg::IDX_W-1:0]     s_entry_index,
    output logic [pir_pkg::STATUS_W-1:0]  m_status,
    output logic [pir_pkg::CNT_OUT_W-1:0] m_entry_count,
    output logic [pir_pkg::IDX_W-1:0]     m_found_position,
    output logic [pir_pkg::ID_W-1:0]      m_entry_id,
    output logic [pir_pkg::PACK_W-1:0]    m_entry_packed
);
    import pir_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [ID_W-1:0] mem [CAPACITY];

    cmd_code_t       op_reg, op_next;
    logic [ID_W-1:0] idv_reg, idv_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic [ID_W-1:0] eid_reg, eid_next;
    status_t         stat_reg, stat_next;
    logic            pack_used_reg, pack_used_next;
    logic [CW-1:0]   rd_addr_reg, rd_addr_next;
    logic [AW-1:0]   data_idx_reg, data_idx_next;
    logic            dvalid_reg, dvalid_next;
    logic            found_reg, found_next;
    logic [ID_W-1:0] rdata_reg;

    logic [STATUS_W-1:0]  res_status_reg;
    logic [CNT_OUT_W-1:0] res_count_reg;
    logic [IDX_W-1:0]     res_pos_reg;
    logic [ID_W-1:0]      res_eid_reg;
    logic [PACK_W-1:0]    res_packed_reg;

    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [ID_W-1:0] mem_wdata;

    logic              full, idx_oor, scan_done, add_go, pack_start, pack_done;
    logic [ID_W-1:0]   pack_in;
    logic [PACK_W-1:0] pack_out;
    logic [ID_W-1:0]   idv_mod;

    logic [CW+IDX_W-1:0]        idx_wide, count_wide;
    logic [AW+IDX_W-1:0]        idx_ext, pos_ext;
    logic [AW-1:0]              idx_addr;
    logic [CW+CNT_OUT_W-1:0]    count_ext;
    logic [CW+AW-1:0]           dix_wide, cnt_wide2;

    always_comb begin
        idv_mod    = (s_id_value >= ID_MODULUS) ? s_id_value - ID_MODULUS : s_id_value;
        idx_wide   = {{CW{1'b0}}, idx_reg};
        count_wide = {{IDX_W{1'b0}}, count_reg};
        idx_ext    = {{AW{1'b0}}, idx_reg};
        idx_addr   = idx_ext[AW-1:0];
        pos_ext    = {{IDX_W{1'b0}}, pos_reg};
        count_ext  = {{CNT_OUT_W{1'b0}}, count_reg};
        dix_wide   = {{CW{1'b0}}, data_idx_reg};
        cnt_wide2  = {{AW{1'b0}}, count_reg};
        full       = count_reg >= CW'(CAPACITY);
        idx_oor    = idx_wide >= count_wide;
        scan_done  = (rd_addr_reg == count_reg) && !dvalid_reg;
        add_go     = cmd.exec && (op_reg == CMD_ADD) && !full;
    end

    always_comb begin
        op_next        = op_reg;
        idv_next       = idv_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        eid_next       = eid_reg;
        stat_next      = stat_reg;
        pack_used_next = pack_used_reg;
        rd_addr_next   = rd_addr_reg;
        data_idx_next  = data_idx_reg;
        dvalid_next    = dvalid_reg;
        found_next     = found_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[AW-1:0];
        mem_wdata      = idv_reg;
        mem_re         = 1'b0;
        mem_raddr      = rd_addr_reg[AW-1:0];
        pack_start     = 1'b0;
        pack_in        = idv_reg;

        if (cmd.load) begin
            op_next        = cmd_code_t'(s_cmd);
            idv_next       = idv_mod;
            idx_next       = s_entry_index;
            pos_next       = '0;
            eid_next       = '0;
            stat_next      = STAT_OK;
            pack_used_next = 1'b0;
        end

        if (cmd.exec) begin
            unique case (op_reg)
                CMD_ADD: begin
                    if (full) begin
                        stat_next = STAT_FULL;
                    end else begin
                        mem_we         = 1'b1;
                        pos_next       = count_reg[AW-1:0];
                        count_next     = count_reg + CW'(1);
                        pack_start     = 1'b1;
                        pack_used_next = 1'b1;
                    end
                end
                CMD_REMOVE: begin
                    rd_addr_next = '0;
                    dvalid_next  = 1'b0;
                    found_next   = 1'b0;
                end
                CMD_READ: begin
                    if (idx_oor) begin
                        stat_next = STAT_RANGE;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_addr;
                        pos_next  = idx_addr;
                    end
                end
                CMD_CLEAR: count_next = '0;
                default:   count_next = count_reg;
            endcase
        end

        // one read issued and one returned entry handled per cycle
        if (cmd.scan_step) begin
            if (rd_addr_reg != count_reg) begin
                mem_re        = 1'b1;
                data_idx_next = rd_addr_reg[AW-1:0];
                dvalid_next   = 1'b1;
                rd_addr_next  = rd_addr_reg + CW'(1);
            end else begin
                dvalid_next = 1'b0;
            end
            if (dvalid_reg) begin
                if (!found_reg) begin
                    if (rdata_reg == idv_reg) begin
                        found_next = 1'b1;
                        pos_next   = data_idx_reg;
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = data_idx_reg - AW'(1);
                    mem_wdata = rdata_reg;
                end
            end
        end

        if (cmd.scan_end) begin
            if (found_reg) begin
                count_next     = count_reg - CW'(1);
                pack_start     = 1'b1;
                pack_used_next = 1'b1;
            end else begin
                stat_next = STAT_NOT_FOUND;
            end
        end

        if (cmd.fetch_take) begin
            eid_next       = rdata_reg;
            pack_start     = 1'b1;
            pack_in        = rdata_reg;
            pack_used_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            dvalid_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            dvalid_reg <= dvalid_next;
        end
        op_reg        <= op_next;
        idv_reg       <= idv_next;
        idx_reg       <= idx_next;
        pos_reg       <= pos_next;
        eid_reg       <= eid_next;
        stat_reg      <= stat_next;
        pack_used_reg <= pack_used_next;
        rd_addr_reg   <= rd_addr_next;
        data_idx_reg  <= data_idx_next;
        found_reg     <= found_next;
        if (cmd.result_load) begin
            res_status_reg <= stat_reg;
            res_count_reg  <= count_ext[CNT_OUT_W-1:0];
            res_pos_reg    <= pos_ext[IDX_W-1:0];
            res_eid_reg    <= eid_reg;
            res_packed_reg <= pack_used_reg ? pack_out : '0;
        end
    end

    pir_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (pack_start),
        .value     (pack_in),
        .done      (pack_done),
        .packed_id (pack_out)
    );

    always_comb begin
        sts.op        = op_reg;
        sts.full      = full;
        sts.idx_oor   = idx_oor;
        sts.scan_done = scan_done;
        sts.found     = found_reg;
        sts.pack_done = pack_done;
    end

    assign m_status         = res_status_reg;
    assign m_entry_count    = res_count_reg;
    assign m_found_position = res_pos_reg;
    assign m_entry_id       = res_eid_reg;
    assign m_entry_packed   = res_packed_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // entries handled by the scan always lie below the count
    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && dvalid_reg) |-> dix_wide < cnt_wide2)
        else $error("scan touched an entry beyond the count");

    a_add_only_with_room: assert property (@(posedge aclk) disable iff (!aresetn)
        add_go |=> count_reg != '0)
        else $error("add did not raise the count");

endmodule

FILE: test/tb_packed_id_registry.sv
// tb_packed_id_registry: self-checking testbench for the packed id registry,
// predicts each result from its own copy of the id list and checks it field by field
// depends on pir_pkg and packed_id_registry
`timescale 1ns / 1ps

module tb_packed_id_registry;
    import pir_pkg::*;

    localparam int LIST_DEPTH     = DEFAULT_CAPACITY;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_PAUSE      = 300;

    typedef struct {
        status_t            status;
        logic [CNT_OUT_W-1:0] count;
        logic [IDX_W-1:0]   position;
        logic [ID_W-1:0]    id;
        logic [PACK_W-1:0]  pair_bytes;
    } registry_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [CMD_W-1:0]     s_cmd = CMD_ADD;
    logic [ID_W-1:0]      s_id_value = '0;
    logic [IDX_W-1:0]     s_entry_index = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [CNT_OUT_W-1:0] m_entry_count;
    logic [IDX_W-1:0]     m_found_position;
    logic [ID_W-1:0]      m_entry_id;
    logic [PACK_W-1:0]    m_entry_packed;

    logic [ID_W-1:0]  id_store [LIST_DEPTH];
    int               id_count = 0;
    registry_result_t pending_results[$];
    int               error_count = 0;
    int               results_seen = 0;
    int               quiet_cycles = 0;
    bit               idle_on = 1'b1;

    packed_id_registry dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_id_value       (s_id_value),
        .s_entry_index    (s_entry_index),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_entry_count    (m_entry_count),
        .m_found_position (m_found_position),
        .m_entry_id       (m_entry_id),
        .m_entry_packed   (m_entry_packed)
    );

    always #4 aclk = ~aclk;

    function automatic logic [PACK_W-1:0] encode_pairs(int v);
        logic [7:0] hi;
        logic [7:0] mid;
        logic [7:0] lo;
        hi  = 8'((v / 10000) % 100) | PAIR_MARK;
        mid = 8'((v % 10000) / 100) | PAIR_MARK;
        lo  = 8'(v % 100) | PAIR_MARK;
        return {hi, mid, lo};
    endfunction

    function automatic int decode_pairs(logic [PACK_W-1:0] p);
        return int'(p[22:16]) * 10000 + int'(p[14:8]) * 100 + int'(p[6:0]);
    endfunction

    // updates the list copy and returns the result the request should produce
    function automatic registry_result_t predict_registry(cmd_code_t op, logic [ID_W-1:0] raw_id,
                                                          logic [IDX_W-1:0] idx);
        registry_result_t r;
        int idv;
        int hit;
        idv = int'(raw_id) % int'(ID_MODULUS);
        r.status = STAT_OK;
        r.position = '0;
        r.id = '0;
        r.pair_bytes = '0;
        case (op)
            CMD_ADD: begin
                if (id_count >= LIST_DEPTH) begin
                    r.status = STAT_FULL;
                end else begin
                    r.position = IDX_W'(id_count);
                    id_store[id_count] = ID_W'(idv);
                    id_count++;
                    r.pair_bytes = encode_pairs(idv);
                end
            end
            CMD_REMOVE: begin
                hit = -1;
                for (int i = 0; i < id_count; i++) begin
                    if (hit < 0 && int'(id_store[i]) == idv) hit = i;
                end
                if (hit < 0) begin
                    r.status = STAT_NOT_FOUND;
                end else begin
                    r.position = IDX_W'(hit);
                    r.pair_bytes = encode_pairs(idv);
                    for (int i = hit; i + 1 < id_count; i++) id_store[i] = id_store[i + 1];
                    id_count--;
                end
            end
            CMD_READ: begin
                if (int'(idx) >= id_count) begin
                    r.status = STAT_RANGE;
                end else begin
                    r.position = idx;
                    r.pair_bytes = encode_pairs(int'(id_store[idx]));
                    r.id = ID_W'(decode_pairs(r.pair_bytes));
                end
            end
            default: begin
                id_count = 0;
            end
        endcase
        r.count = CNT_OUT_W'(id_count);
        return r;
    endfunction

    task automatic report_error(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int got, int want);
        if (got != want)
            report_error($sformatf("result %0d %s: got %0d, expected %0d",
                                   results_seen, name, got, want));
    endtask

    // valid stays high after acceptance until the next request or an explicit drop
    task automatic send_request(cmd_code_t op, logic [ID_W-1:0] idv, logic [IDX_W-1:0] idx);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= op;
        s_id_value <= idv;
        s_entry_index <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_registry(op, idv, idx));
    endtask

    function automatic logic [ID_W-1:0] random_raw_id();
        return ID_W'($urandom);
    endfunction

    task automatic send_random_request();
        int pick;
        int k;
        cmd_code_t op;
        logic [ID_W-1:0] idv;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(0, 99);
        idv = random_raw_id();
        idx = IDX_W'($urandom);
        if (pick < 42) begin
            op = CMD_ADD;
            if ($urandom_range(0, 1) == 1) idv = ID_W'(999990 + $urandom_range(0, 9));
        end else if (pick < 68) begin
            op = CMD_REMOVE;
            if (id_count > 0 && $urandom_range(0, 3) != 0) begin
                k = $urandom_range(0, id_count - 1);
                idv = id_store[k];
                // same low six digits, above the modulus
                if (idv < 20'd48576 && $urandom_range(0, 1) == 1) idv = idv + ID_MODULUS;
            end
        end else if (pick < 97) begin
            op = CMD_READ;
            if (id_count > 0 && $urandom_range(0, 4) != 0)
                idx = IDX_W'($urandom_range(0, id_count - 1));
        end else begin
            op = CMD_CLEAR;
        end
        send_request(op, idv, idx);
    endtask

    task automatic test_directed();
        send_request(CMD_CLEAR, random_raw_id(), IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'd0);
        send_request(CMD_REMOVE, 20'd0, IDX_W'($urandom));
        send_request(CMD_ADD, 20'd0, 8'hFF);
        send_request(CMD_ADD, 20'd999999, 8'h00);
        send_request(CMD_ADD, 20'd1000000, IDX_W'($urandom));
        send_request(CMD_ADD, 20'hFFFFF, IDX_W'($urandom));
        send_request(CMD_ADD, 20'd123456, IDX_W'($urandom));
        send_request(CMD_ADD, 20'd123456, IDX_W'($urandom));
        for (int i = 0; i < 6; i++) send_request(CMD_READ, random_raw_id(), IDX_W'(i));
        send_request(CMD_READ, random_raw_id(), 8'hFF);
        send_request(CMD_REMOVE, 20'd48575, IDX_W'($urandom));
        send_request(CMD_REMOVE, 20'd123456, IDX_W'($urandom));
        send_request(CMD_REMOVE, 20'd777777, IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'd3);
        send_request(CMD_READ, random_raw_id(), 8'd2);
        send_request(CMD_REMOVE, 20'd0, IDX_W'($urandom));
        send_request(CMD_CLEAR, random_raw_id(), IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'd0);
    endtask

    task automatic test_fill_to_full();
        logic [ID_W-1:0] idv;
        send_request(CMD_CLEAR, random_raw_id(), IDX_W'($urandom));
        for (int i = 0; i < LIST_DEPTH; i++) begin
            idv = ($urandom_range(0, 1) == 1) ? random_raw_id() : ID_W'($urandom_range(0, 31));
            send_request(CMD_ADD, idv, IDX_W'($urandom));
        end
        for (int i = 0; i < 3; i++) send_request(CMD_ADD, random_raw_id(), IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'hFF);
        send_request(CMD_READ, random_raw_id(), 8'h00);
        send_request(CMD_REMOVE, id_store[128], IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'hFF);
        send_request(CMD_REMOVE, id_store[id_count - 1], IDX_W'($urandom));
        send_request(CMD_REMOVE, 20'd654321, IDX_W'($urandom));
        send_request(CMD_ADD, 20'd999999, IDX_W'($urandom));
        send_request(CMD_ADD, 20'hFFFFF, IDX_W'($urandom));
        send_request(CMD_ADD, 20'd5, IDX_W'($urandom));
        send_request(CMD_READ, random_raw_id(), 8'hFF);
        send_request(CMD_REMOVE, id_store[0], IDX_W'($urandom));
    endtask

    task automatic test_random_mixed();
        repeat (300) send_random_request();
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (80) send_random_request();
    endtask

    // result side: random stall bursts while idling is on
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (idle_on && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        registry_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_error($sformatf("result with no request pending, status %0d count %0d",
                                       m_status, m_entry_count));
            end else begin
                want = pending_results.pop_front();
                check_field("status", m_status, want.status);
                check_field("entry_count", m_entry_count, want.count);
                check_field("found_position", m_found_position, want.position);
                check_field("entry_id", m_entry_id, want.id);
                check_field("entry_packed", m_entry_packed, want.pair_bytes);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_fill_to_full();
        test_random_mixed();
        test_steady_stream();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (END_PAUSE) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
